@@ sv/kds_pkg.sv @@
// ----------------------------------------------------------------------------
// kds_pkg
// Shared types and constants of the keyed deque with search.
// ----------------------------------------------------------------------------
`default_nettype none

package kds_pkg;

    localparam int KDS_DEPTH = 16;
    localparam int KEY_W     = 32;
    localparam int ACT_W     = 2;

    localparam logic [ACT_W-1:0] ACT_FRONT  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_BACK   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd2;

    typedef enum logic [1:0] {
        OP_FRONT,
        OP_BACK,
        OP_SEARCH,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [KEY_W-1:0] key;
    } t_cmd;

endpackage

`default_nettype wire

@@ sv/keyed_deque_with_search_unit.sv @@
// ----------------------------------------------------------------------------
// keyed_deque_with_search_unit
// Bounded ring of signed keys with front insert, back insert and
// front-to-back search for the first equal key.
// ----------------------------------------------------------------------------
//  channel   | valid    | stall    | payload
//  input     | i_valid  | o_stall  | i_action, i_key
//  result    | o_valid  | i_stall  | o_status, o_found, o_position, o_entry_count
//
//  inserts and unused actions: result registered in the cycle after the back end pops them
//  search over n held keys: one key per cycle from the
//  single read port of the key ram
//  reset clears pointers, count and queue; the key ram is not cleared
//  a stalled result holds; the front keeps taking up to two more beats
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_deque_with_search_unit #(
    parameter int DEPTH = kds_pkg::KDS_DEPTH
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire logic [kds_pkg::ACT_W-1:0]        i_action,
    input  wire logic signed [kds_pkg::KEY_W-1:0] i_key,
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output logic                                  o_status,
    output logic                                  o_found,
    output logic [$clog2(DEPTH)-1:0]              o_position,
    output logic [$clog2(DEPTH+1)-1:0]            o_entry_count
);

    import kds_pkg::*;

    t_cmd cmd;
    logic cmd_valid;
    logic cmd_pop;

    kds_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_action    (i_action),
        .i_key       (i_key),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop)
    );

    kds_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cmd_valid   (cmd_valid),
        .o_cmd_pop     (cmd_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_found       (o_found),
        .o_position    (o_position),
        .o_entry_count (o_entry_count)
    );

endmodule

`default_nettype wire

@@ sv/kds_ram.sv @@
// ----------------------------------------------------------------------------
// kds_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kds_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ sv/kds_front.sv @@
// ----------------------------------------------------------------------------
// kds_front
// Accepts input beats, decodes the action and buffers commands in a
// two-entry queue toward the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module kds_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [kds_pkg::ACT_W-1:0]     i_action,
    input  wire logic signed [kds_pkg::KEY_W-1:0] i_key,
    output kds_pkg::t_cmd                      o_cmd,
    output logic                               o_cmd_valid,
    input  wire logic                          i_cmd_pop
);

    import kds_pkg::*;

    localparam logic [1:0] Q_FULL = 2'd2;

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       dec;
    logic       push;

    // action decode
    always_comb begin
        dec.key = $unsigned(i_key);
        unique case (i_action)
            ACT_FRONT:  dec.op = OP_FRONT;
            ACT_BACK:   dec.op = OP_BACK;
            ACT_SEARCH: dec.op = OP_SEARCH;
            default:    dec.op = OP_NOP;
        endcase
    end

    assign o_stall     = (r_cnt == Q_FULL);
    assign push        = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_cmd_pop};
        end
    end

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_pop |-> o_cmd_valid)
        else $error("pop from empty command queue");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("command queue overflow");

endmodule

`default_nettype wire

@@ sv/kds_back.sv @@
// ----------------------------------------------------------------------------
// kds_back
// Executes commands on the key ring: front and back inserts, and a
// front-to-back search reading one key per cycle from the key RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module kds_back #(
    parameter int DEPTH = kds_pkg::KDS_DEPTH
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire kds_pkg::t_cmd                i_cmd,
    input  wire logic                         i_cmd_valid,
    output logic                              o_cmd_pop,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic                              o_status,
    output logic                              o_found,
    output logic [$clog2(DEPTH)-1:0]          o_position,
    output logic [$clog2(DEPTH+1)-1:0]        o_entry_count
);

    import kds_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_SEARCH = 1'b1;

    logic             r_state, n_state;
    logic [AW-1:0]    r_front, n_front;
    logic [CW-1:0]    r_count, n_count;
    logic [AW-1:0]    r_addr, n_addr;
    logic [AW-1:0]    r_idx, n_idx;
    logic [KEY_W-1:0] r_key, n_key;
    logic             r_ov, n_ov;
    logic             r_status, n_status;
    logic             r_found, n_found;
    logic [AW-1:0]    r_pos, n_pos;
    logic [CW-1:0]    r_cnt_out, n_cnt_out;

    logic             we;
    logic [AW-1:0]    waddr, raddr;
    logic [KEY_W-1:0] rdata;
    logic [AW-1:0]    front_dec, back_slot, next_addr;
    logic [AW:0]      back_sum, idx_nxt;
    logic             full, pop, last;

    kds_ram #(
        .WIDTH (KEY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_cmd.key),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // ring slot arithmetic
    assign front_dec = (r_front == '0) ? AW'(DEPTH - 1) : r_front - 1'b1;
    assign back_sum  = {1'b0, r_front} + (AW+1)'(r_count);
    assign back_slot = (back_sum >= (AW+1)'(DEPTH)) ? AW'(back_sum - (AW+1)'(DEPTH))
                                                     : back_sum[AW-1:0];
    assign next_addr = (r_addr == AW'(DEPTH - 1)) ? '0 : r_addr + 1'b1;
    assign idx_nxt   = {1'b0, r_idx} + 1'b1;
    assign last      = (idx_nxt == (AW+1)'(r_count));
    assign full      = (r_count == CW'(DEPTH));

    assign pop       = i_cmd_valid && (r_state == ST_IDLE) && (!r_ov || !i_stall);
    assign o_cmd_pop = pop;

    always_comb begin
        n_state   = r_state;
        n_front   = r_front;
        n_count   = r_count;
        n_addr    = r_addr;
        n_idx     = r_idx;
        n_key     = r_key;
        n_ov      = r_ov && i_stall;
        n_status  = r_status;
        n_found   = r_found;
        n_pos     = r_pos;
        n_cnt_out = r_cnt_out;
        we        = 1'b0;
        waddr     = back_slot;
        raddr     = r_addr;

        unique case (r_state)
            ST_IDLE: begin
                if (pop) begin
                    case (i_cmd.op) inside
                        OP_FRONT, OP_BACK: begin
                            n_ov     = 1'b1;
                            n_found  = 1'b0;
                            n_pos    = '0;
                            if (full) begin
                                n_status  = 1'b1;
                                n_cnt_out = r_count;
                            end else begin
                                we        = 1'b1;
                                n_status  = 1'b0;
                                n_count   = r_count + 1'b1;
                                n_cnt_out = r_count + 1'b1;
                                if (i_cmd.op == OP_FRONT) begin
                                    n_front = front_dec;
                                    waddr   = front_dec;
                                end
                            end
                        end
                        OP_SEARCH: begin
                            if (r_count == '0) begin
                                n_ov      = 1'b1;
                                n_status  = 1'b0;
                                n_found   = 1'b0;
                                n_pos     = '0;
                                n_cnt_out = r_count;
                            end else begin
                                raddr   = r_front;
                                n_addr  = r_front;
                                n_idx   = '0;
                                n_key   = i_cmd.key;
                                n_state = ST_SEARCH;
                            end
                        end
                        default: begin
                            n_ov      = 1'b1;
                            n_status  = 1'b0;
                            n_found   = 1'b0;
                            n_pos     = '0;
                            n_cnt_out = r_count;
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                raddr  = next_addr;
                n_addr = next_addr;
                n_idx  = idx_nxt[AW-1:0];
                if ((rdata == r_key) || last) begin
                    n_state   = ST_IDLE;
                    n_ov      = 1'b1;
                    n_status  = 1'b0;
                    n_found   = (rdata == r_key);
                    n_pos     = (rdata == r_key) ? r_idx : '0;
                    n_cnt_out = r_count;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_addr    <= n_addr;
        r_idx     <= n_idx;
        r_key     <= n_key;
        r_status  <= n_status;
        r_found   <= n_found;
        r_pos     <= n_pos;
        r_cnt_out <= n_cnt_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_front <= '0;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
            r_ov    <= n_ov;
        end
    end

    assign o_valid       = r_ov;
    assign o_status      = r_status;
    assign o_found       = r_found;
    assign o_position    = r_pos;
    assign o_entry_count = r_cnt_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_search_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEARCH) |-> !r_ov)
        else $error("search running while result beat pending");

    a_found_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> (CW'(o_position) < o_entry_count))
        else $error("match position beyond entry count");

    a_refused_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (o_entry_count == CW'(DEPTH) && !o_found))
        else $error("insert refused while store not full");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks keyed_deque_with_search_unit against a cycle-free model of the key
// ring. A short directed run covers the key extremes, all actions, the empty
// list, the unused action and duplicate keys. A random run then fills the
// ring and searches it, mostly for stored keys. Both channels idle and stall
// at random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------

module testbench;

    import kds_pkg::*;

    localparam int DEPTH = KDS_DEPTH;
    localparam int POS_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef struct packed {
        logic             status;
        logic             found;
        logic [POS_W-1:0] position;
        logic [CNT_W-1:0] entry_count;
    } t_lookup;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic [ACT_W-1:0]        i_action = '0;
    logic signed [KEY_W-1:0] i_key = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic                    o_status;
    logic                    o_found;
    logic [POS_W-1:0]        o_position;
    logic [CNT_W-1:0]        o_entry_count;

    keyed_deque_with_search_unit #(
        .DEPTH(DEPTH)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_action      (i_action),
        .i_key         (i_key),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_found       (o_found),
        .o_position    (o_position),
        .o_entry_count (o_entry_count)
    );

    t_cmd    pending_cmds[$];
    t_lookup expected_lookups[$];

    logic [KEY_W-1:0] ring_keys[DEPTH];
    logic [POS_W-1:0] ring_front = '0;
    logic [CNT_W-1:0] ring_count = '0;

    logic             in_beat = 1'b0;
    int               items_taken = 0;
    int               error_count = 0;
    int               hold_left = 0;
    logic             hold_done = 1'b0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("simulation failed");
        $finish;
    end

    // model of the ring: applies one command, returns its lookup result
    function automatic t_lookup apply_command(input t_op op, input logic [KEY_W-1:0] key);
        t_lookup          r;
        logic [POS_W-1:0] slot;
        int               i;
        r = '0;
        case (op)
            OP_FRONT, OP_BACK: begin
                if (ring_count == CNT_W'(DEPTH)) begin
                    r.status = 1'b1;
                end else if (op == OP_FRONT) begin
                    ring_front = ring_front - 1'b1;
                    ring_keys[ring_front] = key;
                    ring_count = ring_count + 1'b1;
                end else begin
                    slot = ring_front + POS_W'(ring_count);
                    ring_keys[slot] = key;
                    ring_count = ring_count + 1'b1;
                end
            end
            OP_SEARCH: begin
                for (i = 0; i < int'(ring_count) && !r.found; i++) begin
                    slot = ring_front + POS_W'(i);
                    if (ring_keys[slot] == key) begin
                        r.found = 1'b1;
                        r.position = POS_W'(i);
                    end
                end
            end
            default: begin
            end
        endcase
        r.entry_count = ring_count;
        return r;
    endfunction

    function automatic logic calm_window();
        return items_taken >= 700 && items_taken < 900;
    endfunction

    task automatic queue_cmd(input t_op op, input logic [KEY_W-1:0] key);
        t_cmd c;
        c.op = op;
        c.key = key;
        pending_cmds.push_back(c);
    endtask

    // input channel driver
    always @(negedge i_clk) begin
        t_cmd c;
        logic offer;
        if (i_rst_n && (!i_valid || in_beat)) begin
            offer = pending_cmds.size() != 0 && (calm_window() || $urandom_range(99) >= 35);
            if (offer) begin
                c = pending_cmds.pop_front();
                i_action <= c.op;
                i_key <= c.key;
            end
            i_valid <= offer;
        end
    end

    // result channel stall, with one long hold-off once the ring is busy
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else if (!hold_done && items_taken >= 400) begin
            hold_done = 1'b1;
            hold_left = 250;
            i_stall <= 1'b1;
        end else begin
            i_stall <= !calm_window() && $urandom_range(99) < 35;
        end
    end

    // beat monitor and checker
    always @(posedge i_clk) begin
        t_lookup want;
        if (i_rst_n) begin
            in_beat = i_valid && !o_stall;
            if (in_beat) begin
                expected_lookups.push_back(apply_command(t_op'(i_action), i_key));
                items_taken++;
            end
            if (o_valid && !i_stall) begin
                if (expected_lookups.size() == 0) begin
                    $error("result beat with nothing expected");
                    error_count++;
                end else begin
                    want = expected_lookups.pop_front();
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        error_count++;
                    end
                    if (o_found !== want.found) begin
                        $error("found: expected %0d, got %0d", want.found, o_found);
                        error_count++;
                    end
                    if (o_position !== want.position) begin
                        $error("position: expected %0d, got %0d", want.position, o_position);
                        error_count++;
                    end
                    if (o_entry_count !== want.entry_count) begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, o_entry_count);
                        error_count++;
                    end
                end
            end
        end else begin
            in_beat = 1'b0;
        end
    end

    initial begin
        logic [KEY_W-1:0] stored[$];
        logic [KEY_W-1:0] k;
        int               roll;
        int               n;

        // empty list, unused action, key extremes, front insert into empty
        queue_cmd(OP_SEARCH, 32'h0000_0000);
        queue_cmd(OP_NOP,    32'hFFFF_FFFF);
        queue_cmd(OP_FRONT,  32'h8000_0000);
        queue_cmd(OP_BACK,   32'h7FFF_FFFF);
        queue_cmd(OP_FRONT,  32'hFFFF_FFFF);
        queue_cmd(OP_BACK,   32'h0000_0000);
        queue_cmd(OP_SEARCH, 32'hFFFF_FFFF);
        queue_cmd(OP_SEARCH, 32'h8000_0000);
        queue_cmd(OP_SEARCH, 32'h7FFF_FFFF);
        queue_cmd(OP_SEARCH, 32'h0000_0000);
        queue_cmd(OP_SEARCH, 32'h1234_5678);
        queue_cmd(OP_NOP,    32'h0000_0000);
        // duplicate key, first match wins
        queue_cmd(OP_BACK,   32'h8000_0000);
        queue_cmd(OP_SEARCH, 32'h8000_0000);
        stored = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
                   32'h8000_0000};

        for (n = 0; n < 1336; n++) begin
            roll = $urandom_range(99);
            if (roll < 18) begin
                if ($urandom_range(3) == 0) k = stored[$urandom_range(stored.size() - 1)];
                else k = $urandom;
                if (stored.size() < DEPTH) stored.push_back(k);
                queue_cmd($urandom_range(1) ? OP_FRONT : OP_BACK, k);
            end else if (roll < 23) begin
                queue_cmd(OP_NOP, $urandom);
            end else if (roll < 33) begin
                queue_cmd(OP_SEARCH, $urandom);
            end else if (roll < 41) begin
                k = stored[$urandom_range(stored.size() - 1)];
                k[$urandom_range(KEY_W - 1)] ^= 1'b1;
                queue_cmd(OP_SEARCH, k);
            end else begin
                queue_cmd(OP_SEARCH, stored[$urandom_range(stored.size() - 1)]);
            end
        end

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk); while (pending_cmds.size() != 0 || i_valid);
        while (expected_lookups.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);

        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/kds_pkg.sv
sv/kds_ram.sv
sv/kds_front.sv
sv/kds_back.sv
sv/keyed_deque_with_search_unit.sv
tb/testbench.sv
